@@ sv/tcl_pkg.sv @@
// Shared types and constants for the tile cache lookup.
// Used by tcl_cell and tile_cache_lru_lookup; depends on nothing.
`default_nettype none
package tcl_pkg;
    localparam int ENTRIES_DEF = 128;
    localparam int MAX_LEVEL_DEF = 18;
    localparam int KEY_COORD_W = 24;
    localparam int STAMP_W = 64;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [4:0] level;
        logic signed [19:0] column;
        logic signed [19:0] row;
    } req_t;

    typedef struct packed {
        logic skipped;
        logic hit;
        logic [6:0] slot;
        logic [17:0] wrapped_column;
        logic evicted;
        logic [4:0] evicted_level;
        logic [17:0] evicted_column;
        logic [17:0] evicted_row;
    } result_t;

    typedef struct packed {
        logic [4:0] level;
        logic [KEY_COORD_W-1:0] column;
        logic [KEY_COORD_W-1:0] row;
    } key_t;

    typedef struct packed {
        logic found;
        logic have_valid;
        logic have_invalid;
        logic victim_valid;
        key_t victim_key;
        logic [STAMP_W-1:0] best;
    } token_t;

    typedef struct packed {
        logic stamp_en;
        logic key_en;
        key_t key;
        logic [STAMP_W-1:0] stamp;
    } write_t;
endpackage
`default_nettype wire

@@ sv/tcl_cell.sv @@
// One slot of the tag store with its stage of the search chain.
// Depends on tcl_pkg.
`default_nettype none
module tcl_cell #(
    parameter int IDX_W = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire tcl_pkg::key_t     search_key,
    input  wire logic              live_in,
    input  wire tcl_pkg::token_t   tok_in,
    input  wire logic [IDX_W-1:0]  victim_in,
    output logic                   live_out,
    output tcl_pkg::token_t        tok_out,
    output logic [IDX_W-1:0]       victim_out,
    input  wire tcl_pkg::write_t   wr,
    input  wire logic [IDX_W-1:0]  wr_index
);
    logic                         valid_reg;
    tcl_pkg::key_t                key_reg;
    logic [tcl_pkg::STAMP_W-1:0]  stamp_reg;
    logic                         live_reg;
    tcl_pkg::token_t              tok_reg;
    tcl_pkg::token_t              tok_next;
    logic [IDX_W-1:0]             victim_reg;
    logic [IDX_W-1:0]             victim_next;
    logic                         sel;

    assign sel = (wr_index == cell_index);

    always_comb
    begin
        tok_next = tok_in;
        victim_next = victim_in;
        if (!tok_in.found) begin
            if (valid_reg) begin
                if (key_reg == search_key) begin
                    tok_next.found = 1'b1;
                    victim_next = cell_index;
                end else if (!tok_in.have_invalid &&
                             (!tok_in.have_valid || stamp_reg < tok_in.best)) begin
                    tok_next.best = stamp_reg;
                    tok_next.have_valid = 1'b1;
                    tok_next.victim_valid = 1'b1;
                    tok_next.victim_key = key_reg;
                    victim_next = cell_index;
                end
            end else begin
                tok_next.have_invalid = 1'b1;
                tok_next.victim_valid = 1'b0;
                victim_next = cell_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            live_reg <= 1'b0;
        end else begin
            live_reg <= live_in;
            if (wr.key_en && sel) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        victim_reg <= victim_next;
        if (wr.key_en && sel) begin
            key_reg <= wr.key;
        end
        if (wr.stamp_en && sel) begin
            stamp_reg <= wr.stamp;
        end
    end

    assign live_out = live_reg;
    assign tok_out = tok_reg;
    assign victim_out = victim_reg;
endmodule
`default_nettype wire

@@ sv/tile_cache_lru_lookup.sv @@
// Top level of the tile cache lookup: request decode, control and the cell chain.
// Depends on tcl_pkg and tcl_cell.
`default_nettype none
// A request whose row lies outside the level's range gives its result beat in the
// cycle after it is taken. Any other request walks a search token down the chain
// of ENTRIES cells, one cell per cycle, and busy stays high while the token is in
// the chain. Its result beat is registered from the last cell's output. The result
// is shown on the result port for one cycle with strobe high and cannot be held.
// The replacement slot is written in the cycle the result is registered.
module tile_cache_lru_lookup #(
    parameter int ENTRIES = tcl_pkg::ENTRIES_DEF,
    parameter int MAX_LEVEL = tcl_pkg::MAX_LEVEL_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tcl_pkg::req_t    request,
    output logic                  busy,
    output logic                  strobe,
    output tcl_pkg::result_t      result
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    tcl_pkg::state_t              state_reg;
    tcl_pkg::state_t              state_next;
    tcl_pkg::key_t                key_reg;
    tcl_pkg::key_t                key_next;
    logic [tcl_pkg::STAMP_W-1:0]  stamp_reg;
    logic [tcl_pkg::STAMP_W-1:0]  stamp_next;
    logic                         go_reg;
    logic                         strobe_reg;
    logic                         strobe_next;
    tcl_pkg::result_t             result_reg;
    tcl_pkg::result_t             result_next;
    logic                         accept;
    logic                         skip;
    logic                         launch;
    logic [4:0]                   lvl_sat;
    logic signed [31:0]           col32;
    logic signed [31:0]           row32;
    logic [31:0]                  mask32;
    logic [31:0]                  wcol32;
    logic [31:0]                  slot32;
    logic [31:0]                  ecol32;
    logic [31:0]                  erow32;
    logic                         live_last;
    tcl_pkg::token_t              tok_last;
    logic [IDX_W-1:0]             victim_last;
    tcl_pkg::write_t              wr;

    logic                         live_c [0:ENTRIES];
    tcl_pkg::token_t              tok_c [0:ENTRIES];
    logic [IDX_W-1:0]             vic_c [0:ENTRIES];

    assign accept = start && !busy;
    assign lvl_sat = (request.level > 5'(MAX_LEVEL)) ? 5'(MAX_LEVEL) : request.level;
    assign col32 = 32'(request.column);
    assign row32 = 32'(request.row);
    assign mask32 = (32'd1 << lvl_sat) - 32'd1;
    assign wcol32 = col32 & mask32;
    assign skip = row32[31] || ((row32 >> lvl_sat) != 32'd0);

    always_comb
    begin
        key_next.level = lvl_sat;
        key_next.column = wcol32[tcl_pkg::KEY_COORD_W-1:0];
        key_next.row = row32[tcl_pkg::KEY_COORD_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcl_pkg::ST_IDLE:
            begin
                if (accept && !skip) begin
                    state_next = tcl_pkg::ST_SCAN;
                end
            end
            tcl_pkg::ST_SCAN:
            begin
                if (live_last) begin
                    state_next = tcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b0;
        launch = 1'b0;
        case (state_reg)
            tcl_pkg::ST_IDLE:
            begin
                launch = accept && !skip;
            end
            tcl_pkg::ST_SCAN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        live_c[0] = go_reg;
        tok_c[0].found = 1'b0;
        tok_c[0].have_valid = 1'b0;
        tok_c[0].have_invalid = 1'b0;
        tok_c[0].victim_valid = 1'b0;
        tok_c[0].victim_key = key_reg;
        tok_c[0].best = '0;
        vic_c[0] = '0;
    end

    assign live_last = live_c[ENTRIES];
    assign tok_last = tok_c[ENTRIES];
    assign victim_last = vic_c[ENTRIES];
    assign stamp_next = stamp_reg + 64'd1;

    always_comb
    begin
        wr.stamp_en = live_last;
        wr.key_en = live_last && !tok_last.found;
        wr.key = key_reg;
        wr.stamp = stamp_next;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            tcl_cell #(
                .IDX_W(IDX_W)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .cell_index(IDX_W'(g)),
                .search_key(key_reg),
                .live_in(live_c[g]),
                .tok_in(tok_c[g]),
                .victim_in(vic_c[g]),
                .live_out(live_c[g+1]),
                .tok_out(tok_c[g+1]),
                .victim_out(vic_c[g+1]),
                .wr(wr),
                .wr_index(victim_last)
            );
        end
    endgenerate

    assign slot32 = 32'(victim_last);
    assign ecol32 = 32'(tok_last.victim_key.column);
    assign erow32 = 32'(tok_last.victim_key.row);

    always_comb
    begin
        result_next = '0;
        strobe_next = 1'b0;
        if (accept && skip) begin
            strobe_next = 1'b1;
            result_next.skipped = 1'b1;
        end else if (live_last) begin
            strobe_next = 1'b1;
            result_next.hit = tok_last.found;
            result_next.slot = slot32[6:0];
            result_next.wrapped_column = key_reg.column[17:0];
            if (!tok_last.found && tok_last.victim_valid) begin
                result_next.evicted = 1'b1;
                result_next.evicted_level = tok_last.victim_key.level;
                result_next.evicted_column = ecol32[17:0];
                result_next.evicted_row = erow32[17:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= tcl_pkg::ST_IDLE;
            stamp_reg <= '0;
            go_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg <= launch;
            strobe_reg <= strobe_next;
            if (live_last) begin
                stamp_reg <= stamp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch) begin
            key_reg <= key_next;
        end
        if (strobe_next) begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.hit || result.skipped)) |-> !result.evicted)
        else $error("Eviction reported on a hit or skipped beat.");
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcl_pkg::ST_SCAN && live_last) |=>
        (state_reg == tcl_pkg::ST_IDLE && strobe))
        else $error("Scan end did not produce a result beat.");
    a_skip_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && skip) |=> (strobe && result.skipped))
        else $error("Skipped request gave no skipped beat.");
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.skipped) |-> (stamp_reg == $past(stamp_reg) + 64'd1))
        else $error("Stamp counter did not advance on a lookup.");
`endif
endmodule
`default_nettype wire
